// File: rtl/srmv_pkg.sv
// Shared types, constants and arithmetic helpers for the sparse matrix-vector multiplier.
// Used by sparse_row_matrix_vector_multiply; no dependencies.
package srmv_pkg;

    localparam int VEC_DEPTH = 1024;
    localparam int VEC_AW    = $clog2(VEC_DEPTH);
    localparam int IDX_W     = 10;

    localparam int RES_DEPTH = 8;
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_NONZERO = 2'd1,
        CMD_READ    = 2'd2
    } cmd_t;

    typedef struct packed {
        logic               sat;
        logic signed [63:0] value;
    } acc_word_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [IDX_W-1:0]   index;
        logic               sat;
    } result_t;

    function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
        return {{(32-IDX_W){1'b0}}, idx} < 32'(VEC_DEPTH);
    endfunction

    function automatic logic [VEC_AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
        return VEC_AW'(idx);
    endfunction

    function automatic acc_word_t sat_add(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
        logic signed [63:0] sum;
        acc_word_t          r;
        sum = a + b;
        r.sat = (a[63] == b[63]) && (sum[63] != a[63]);
        if (r.sat)
        begin
            r.value = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        else
        begin
            r.value = sum;
        end
        return r;
    endfunction

    // Floor Q32.32 to Q16.16, clamp to 32 bits.
    function automatic result_t narrow(input logic signed [63:0] a, input logic sat_in,
                                       input logic [IDX_W-1:0] index);
        result_t r;
        logic    fits;
        fits    = (&a[63:47]) | ~(|a[63:47]);
        r.index = index;
        if (fits)
        begin
            r.value = a[47:16];
            r.sat   = sat_in;
        end
        else
        begin
            r.value = a[63] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
            r.sat   = 1'b1;
        end
        return r;
    endfunction

endpackage

// File: rtl/srmv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/sparse_row_matrix_vector_multiply.sv
// Sparse matrix-vector multiplier, row gather (A x) and column scatter (A^T x) modes.
// Depends on srmv_pkg and srmv_ram (vector store and accumulator store).
//
// Takes one beat per cycle while item_stall is low: load, nonzero or
// accumulator read. A beat passes a four-stage pipeline (store read, 32x32
// multiply, saturating 64-bit add with forwarding of the two most recent
// accumulator writes, narrowing) and its result, if any, is pushed into the
// result buffer. Results queue in an 8-entry buffer; item_stall rises when
// that buffer plus the beats in flight would fill it, so a stalled result side
// holds off new beats once the buffer and pipeline are full. After reset the
// accumulator store is cleared one entry per cycle, all VEC_DEPTH (1024)
// entries, with item_stall high; the mode register may be written meanwhile.
module sparse_row_matrix_vector_multiply
    import srmv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         cmd,
    input  logic [IDX_W-1:0]   row_index,
    input  logic [IDX_W-1:0]   col_index,
    input  logic signed [31:0] matrix_value,
    input  logic signed [31:0] vector_value,
    input  logic               last_in_row,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] result_value,
    output logic [IDX_W-1:0]   result_index,
    output logic               saturated
);

    typedef struct packed {
        cmd_t               cmd;
        logic [IDX_W-1:0]   row;
        logic               last;
        logic signed [31:0] a;
        logic               vec_ok;
        logic               acc_ok;
        logic [VEC_AW-1:0]  acc_addr;
    } s1_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [IDX_W-1:0]   row;
        logic               last;
        logic               acc_ok;
        logic [VEC_AW-1:0]  acc_addr;
        logic signed [63:0] prod;
        acc_word_t          acc_q;
    } s2_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic               sat;
        logic [IDX_W-1:0]   index;
    } s3_t;

    typedef struct packed {
        logic [VEC_AW-1:0] addr;
        acc_word_t         data;
    } wr_t;

    logic              mode_reg;
    logic              clearing_reg;
    logic [VEC_AW-1:0] clr_addr_reg;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg;
    s3_t  s3_reg, s3_next;
    logic s3_valid_next;

    logic signed [63:0] row_sum_reg, row_sum_next;
    logic               row_sat_reg, row_sat_next;

    logic wr1_valid_reg, wr2_valid_reg, wr_valid_next;
    wr_t  wr1_reg, wr2_reg, wr_next;

    result_t           res_mem_reg [RES_DEPTH];
    logic [RES_AW-1:0] res_head_reg, res_tail_reg;
    logic [RES_CW-1:0] res_count_reg;
    logic [RES_CW:0]   res_used;
    logic              res_push, res_pop;
    result_t           res_in;

    logic               accept;
    cmd_t               cmd_in;
    logic [IDX_W-1:0]   vec_idx, acc_idx;
    logic               vec_we, vec_re;
    logic [31:0]        vec_rdata;
    logic signed [63:0] x_val, prod;
    acc_word_t          acc_rdata, acc_old, gsum, ssum;
    logic               acc_we;
    logic [VEC_AW-1:0]  acc_waddr;
    acc_word_t          acc_wdata;

    // Input side
    assign cmd_in   = cmd_t'(cmd);
    assign res_used = (RES_CW + 1)'(res_count_reg) + (RES_CW + 1)'(s1_valid_reg)
                    + (RES_CW + 1)'(s2_valid_reg) + (RES_CW + 1)'(s3_valid_reg);
    assign item_stall = clearing_reg || (res_used >= (RES_CW + 1)'(RES_DEPTH));
    assign accept     = item_valid && !item_stall;

    assign vec_idx = mode_reg ? row_index : col_index;
    assign acc_idx = (cmd_in == CMD_READ) ? row_index : col_index;
    assign vec_we  = accept && (cmd_in == CMD_LOAD) && idx_ok(row_index);
    assign vec_re  = accept && (cmd_in == CMD_NONZERO);

    always_comb
    begin
        s1_next.cmd      = cmd_in;
        s1_next.row      = row_index;
        s1_next.last     = last_in_row;
        s1_next.a        = matrix_value;
        s1_next.vec_ok   = idx_ok(vec_idx);
        s1_next.acc_ok   = idx_ok(acc_idx);
        s1_next.acc_addr = to_addr(acc_idx);
    end

    srmv_ram #(
        .WIDTH (32),
        .DEPTH (VEC_DEPTH)
    ) u_vec_ram (
        .clk   (clk),
        .we    (vec_we),
        .waddr (to_addr(row_index)),
        .wdata (vector_value),
        .re    (vec_re),
        .raddr (to_addr(vec_idx)),
        .rdata (vec_rdata)
    );

    srmv_ram #(
        .WIDTH ($bits(acc_word_t)),
        .DEPTH (VEC_DEPTH)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .re    (accept),
        .raddr (s1_next.acc_addr),
        .rdata (acc_rdata)
    );

    // Stage 1: multiply
    assign x_val = s1_reg.vec_ok ? 64'(signed'(vec_rdata)) : 64'sd0;
    assign prod  = 64'(s1_reg.a) * x_val;

    // Stage 2: accumulate, forward recent accumulator writes
    always_comb
    begin
        if (wr1_valid_reg && (wr1_reg.addr == s2_reg.acc_addr))
        begin
            acc_old = wr1_reg.data;
        end
        else if (wr2_valid_reg && (wr2_reg.addr == s2_reg.acc_addr))
        begin
            acc_old = wr2_reg.data;
        end
        else
        begin
            acc_old = s2_reg.acc_q;
        end

        gsum = sat_add(row_sum_reg, s2_reg.prod);
        ssum = sat_add(acc_old.value, s2_reg.prod);

        row_sum_next  = row_sum_reg;
        row_sat_next  = row_sat_reg;
        wr_valid_next = 1'b0;
        wr_next.addr  = s2_reg.acc_addr;
        wr_next.data  = '0;
        s3_valid_next = 1'b0;
        s3_next.value = 64'sd0;
        s3_next.sat   = 1'b0;
        s3_next.index = s2_reg.row;

        if (s2_valid_reg)
        begin
            case (s2_reg.cmd)
                CMD_NONZERO:
                begin
                    if (!mode_reg)
                    begin
                        if (s2_reg.last)
                        begin
                            s3_valid_next = 1'b1;
                            s3_next.value = gsum.value;
                            s3_next.sat   = row_sat_reg | gsum.sat;
                            row_sum_next  = 64'sd0;
                            row_sat_next  = 1'b0;
                        end
                        else
                        begin
                            row_sum_next = gsum.value;
                            row_sat_next = row_sat_reg | gsum.sat;
                        end
                    end
                    else if (s2_reg.acc_ok)
                    begin
                        wr_valid_next      = 1'b1;
                        wr_next.data.value = ssum.value;
                        wr_next.data.sat   = acc_old.sat | ssum.sat;
                    end
                end
                CMD_READ:
                begin
                    s3_valid_next = 1'b1;
                    if (s2_reg.acc_ok)
                    begin
                        s3_next.value = acc_old.value;
                        s3_next.sat   = acc_old.sat;
                        wr_valid_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign acc_we    = clearing_reg || wr_valid_next;
    assign acc_waddr = clearing_reg ? clr_addr_reg : wr_next.addr;
    assign acc_wdata = clearing_reg ? acc_word_t'('0) : wr_next.data;

    // Stage 3: narrow into the result buffer
    assign res_in   = narrow(s3_reg.value, s3_reg.sat, s3_reg.index);
    assign res_push = s3_valid_reg;
    assign res_pop  = result_valid && !result_stall;

    assign result_valid = (res_count_reg != '0);
    assign result_value = res_mem_reg[res_head_reg].value;
    assign result_index = res_mem_reg[res_head_reg].index;
    assign saturated    = res_mem_reg[res_head_reg].sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            row_sum_reg   <= 64'sd0;
            row_sat_reg   <= 1'b0;
            wr1_valid_reg <= 1'b0;
            wr2_valid_reg <= 1'b0;
            res_head_reg  <= '0;
            res_tail_reg  <= '0;
            res_count_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == VEC_AW'(VEC_DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s3_valid_next;
            row_sum_reg   <= row_sum_next;
            row_sat_reg   <= row_sat_next;
            wr1_valid_reg <= wr_valid_next;
            wr2_valid_reg <= wr1_valid_reg;
            if (res_push)
            begin
                res_tail_reg <= res_tail_reg + 1'b1;
            end
            if (res_pop)
            begin
                res_head_reg <= res_head_reg + 1'b1;
            end
            if (res_push && !res_pop)
            begin
                res_count_reg <= res_count_reg + 1'b1;
            end
            else if (!res_push && res_pop)
            begin
                res_count_reg <= res_count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        s2_reg.cmd      <= s1_reg.cmd;
        s2_reg.row      <= s1_reg.row;
        s2_reg.last     <= s1_reg.last;
        s2_reg.acc_ok   <= s1_reg.acc_ok;
        s2_reg.acc_addr <= s1_reg.acc_addr;
        s2_reg.prod     <= prod;
        s2_reg.acc_q    <= acc_rdata;
        s3_reg          <= s3_next;
        wr1_reg         <= wr_next;
        wr2_reg         <= wr1_reg;
        if (res_push)
        begin
            res_mem_reg[res_tail_reg] <= res_in;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> item_stall)
        else $error("beat accepted during accumulator clear");

    a_result_buffer_room: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && !res_pop) |-> (res_count_reg != RES_CW'(RES_DEPTH)))
        else $error("result buffer overflow");

    a_row_sum_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && (s2_reg.cmd == CMD_NONZERO) && !mode_reg && s2_reg.last)
        |=> ((row_sum_reg == 64'sd0) && !row_sat_reg))
        else $error("row sum not cleared after last nonzero");

    a_read_clears_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && (s2_reg.cmd == CMD_READ) && s2_reg.acc_ok)
        |=> (wr1_valid_reg && (wr1_reg.data == acc_word_t'('0))))
        else $error("accumulator read did not clear entry");
`endif

endmodule
